### sv/template_salt_expander_core_assert.svh
// Assertion macros for the salt template expander checker.
// No dependencies.
`ifndef TEMPLATE_SALT_EXPANDER_CORE_ASSERT_SVH
`define TEMPLATE_SALT_EXPANDER_CORE_ASSERT_SVH
// Implication checked on every clock, disabled in reset.
`define TSE_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TSE_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### sv/tse_pkg.sv
// Shared types and constants for the salt template expander.
// No dependencies.
`timescale 1ns / 1ps
package tse_pkg;
  typedef enum logic [2:0] {
    P_START, P_IN_GEN, P_SAW_FIRST, P_SAW_THROUGH, P_SAW_GEN, P_IN_COUNT, P_SAW_COUNT
  } pphase_t;
  typedef enum logic [1:0] {L_START, L_ESC, L_OCT} lphase_t;
  typedef enum logic [2:0] {T_EOF, T_OPEN, T_CLOSE, T_DASH, T_LBRACE, T_RBRACE, T_LIT} tok_t;
  typedef enum logic [3:0] {
    S_IDLE, S_LEX, S_PARSE, S_FILL, S_PICK_ADV, S_PICK_MOD, S_PICK_RD, S_PICK_WAIT,
    S_EMIT, S_FINISH
  } seq_t;
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_LIT    = 3'd1;
  localparam logic [2:0] ERR_END    = 3'd2;
  localparam logic [2:0] ERR_BACK   = 3'd3;
  localparam logic [2:0] ERR_DIGIT  = 3'd4;
  localparam logic [2:0] ERR_FULL   = 3'd5;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [7:0] CH_OPEN = 8'h5B, CH_CLOSE = 8'h5D, CH_DASH = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B, CH_RBRACE = 8'h7D, CH_BSL = 8'h5C;
  localparam logic [7:0] CH_0 = 8'h30, CH_3 = 8'h33, CH_7 = 8'h37, CH_9 = 8'h39;
endpackage

### sv/tse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/tse_mod.sv
// Bit-serial 32-by-(up to 32)-bit modulo unit, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module tse_mod #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);
  logic [DW:0]   rem_r, rem_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   shifted;
  always_comb begin
    rem_nxt = rem_r; num_nxt = num_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    shifted = {rem_r[DW-1:0], num_r[31]};
    done = busy_r && (cnt_r == 6'd0);
    if (start) begin
      rem_nxt = '0; num_nxt = dividend; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 6'd0) begin
      rem_nxt = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
      num_nxt = {num_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; num_r <= num_nxt;
  end
  assign remainder = rem_r[DW-1:0];
endmodule

### sv/template_salt_expander_core.sv
// Top level of the salt template expander: lexer, parser sequencer, range store.
// Depends on tse_pkg, tse_ram and tse_mod.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_stall carry template beats (in_template_byte, in_end_of_template).
//   out_valid/out_stall carry result beats (salt byte, kind, error code, last flag).
//   cfg_we with cfg_wdata loads the pick LFSR seed (zero loads 1); write only when idle.
// Each input beat is processed by a sequencer; in_stall is high from the cycle after
// acceptance until the beat's last result is loaded into the output register.
// A plain byte passes through the lex, parse, finish and emit states while in_stall
// is high; each parser step that reuses the same token adds a parse state and an
// escape flushed by the next byte adds a lex and a parse state. A span a-b writes
// one store entry per cycle (up to RANGE_DEPTH entries). Each pick steps the LFSR,
// starts the bit-serial modulo unit, waits for its remainder and then takes the
// registered store read.
// One result is held behind the output register until the next one is produced or
// the beat ends; while out_stall keeps both full the sequencer waits. Reset
// (synchronous, rst_n low) returns the lexer and parser to start, clears the store
// length and loads the LFSR with 1. The range store has no reset; only written
// entries are ever read.
module template_salt_expander_core #(
  parameter int RANGE_DEPTH = 256,
  parameter int COUNT_MAX   = 62
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_template_byte,
  input  logic       in_end_of_template,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_salt_byte,
  output logic [1:0] out_result_kind,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run,
  input  logic       cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam int AW = $clog2(RANGE_DEPTH);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(RANGE_DEPTH);
  localparam logic [5:0] CMAX = 6'(COUNT_MAX);

  tse_pkg::seq_t    st_r, st_nxt;
  tse_pkg::pphase_t pp_r, pp_nxt;
  tse_pkg::lphase_t lp_r, lp_nxt;
  logic [7:0]    c_r, c_nxt, oct_r, oct_nxt, first_r, first_nxt, val_r, val_nxt;
  logic [1:0]    ocnt_r, ocnt_nxt;
  tse_pkg::tok_t tok_r, tok_nxt;
  logic [5:0]    rep_r, rep_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [8:0]    span_r, span_nxt;
  logic [31:0]   lfsr_r, lfsr_nxt;
  logic          disc_r, disc_nxt, halted_r, halted_nxt;
  logic          relex_r, relex_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic [2:0]    oe_r, oe_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    pb_r, pb_nxt;
  logic [1:0]    pk_r, pk_nxt;
  logic [2:0]    pe_r, pe_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic          mstart, mdone;
  logic [LW-1:0] mrem;
  tse_pkg::seq_t ret;

  tse_ram #(.WIDTH(8), .DEPTH(RANGE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));
  tse_mod #(.DW(LW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mstart), .dividend(lfsr_r), .divisor(len_r),
    .done(mdone), .remainder(mrem));

  assign in_stall = (st_r != tse_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_salt_byte = ob_r;
  assign out_result_kind = ok_r;
  assign out_error_code = oe_r;
  assign out_last_of_run = ol_r;

  always_comb begin
    logic pushed;
    logic [9:0] r10;
    logic [8:0] span_w;
    st_nxt = st_r; pp_nxt = pp_r; lp_nxt = lp_r; c_nxt = c_r; oct_nxt = oct_r;
    first_nxt = first_r; val_nxt = val_r; ocnt_nxt = ocnt_r; tok_nxt = tok_r;
    rep_nxt = rep_r; len_nxt = len_r; span_nxt = span_r; lfsr_nxt = lfsr_r;
    disc_nxt = disc_r; halted_nxt = halted_r; relex_nxt = relex_r;
    ov_nxt = ov_r; ol_nxt = ol_r; ob_nxt = ob_r; ok_nxt = ok_r; oe_nxt = oe_r;
    pend_nxt = pend_r; pb_nxt = pb_r; pk_nxt = pk_r; pe_nxt = pe_r;
    we = 1'b0; waddr = len_r[AW-1:0]; wdata = first_r; raddr = mrem[AW-1:0];
    mstart = 1'b0; pushed = 1'b0; r10 = '0; ret = tse_pkg::S_PARSE;
    span_w = {1'b0, val_r - first_r} + 9'd1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (cfg_we) lfsr_nxt = (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
    unique case (st_r)
      tse_pkg::S_IDLE: begin
        if (in_valid) begin
          c_nxt = in_end_of_template ? 8'd0 : in_template_byte;
          halted_nxt = 1'b0;
          if (disc_r) begin
            if (c_nxt == 8'd0) begin
              disc_nxt = 1'b0; pp_nxt = tse_pkg::P_START; lp_nxt = tse_pkg::L_START;
            end
          end else st_nxt = tse_pkg::S_LEX;
        end
      end
      tse_pkg::S_LEX: begin
        st_nxt = tse_pkg::S_FINISH;
        relex_nxt = 1'b0;
        if (!halted_r) begin
          unique case (lp_r)
            tse_pkg::L_ESC: begin
              lp_nxt = tse_pkg::L_START;
              if (c_r == 8'd0) begin
                tok_nxt = tse_pkg::T_LIT; val_nxt = tse_pkg::CH_BSL; relex_nxt = 1'b1;
                st_nxt = tse_pkg::S_PARSE;
              end else if (c_r >= tse_pkg::CH_0 && c_r <= tse_pkg::CH_3) begin
                oct_nxt = c_r - tse_pkg::CH_0; ocnt_nxt = 2'd1; lp_nxt = tse_pkg::L_OCT;
              end else begin
                tok_nxt = tse_pkg::T_LIT; val_nxt = c_r; st_nxt = tse_pkg::S_PARSE;
              end
            end
            tse_pkg::L_OCT: begin
              if (c_r >= tse_pkg::CH_0 && c_r <= tse_pkg::CH_7 && ocnt_r != 2'd3) begin
                oct_nxt = {oct_r[4:0], 3'b000} + (c_r - tse_pkg::CH_0);
                ocnt_nxt = ocnt_r + 2'd1;
              end else begin
                lp_nxt = tse_pkg::L_START; tok_nxt = tse_pkg::T_LIT; val_nxt = oct_r;
                relex_nxt = 1'b1; st_nxt = tse_pkg::S_PARSE;
              end
            end
            default: begin
              lp_nxt = tse_pkg::L_START; val_nxt = c_r; st_nxt = tse_pkg::S_PARSE;
              priority if (c_r == 8'd0) tok_nxt = tse_pkg::T_EOF;
              else if (c_r == tse_pkg::CH_BSL) begin
                lp_nxt = tse_pkg::L_ESC; st_nxt = tse_pkg::S_FINISH;
              end
              else if (c_r == tse_pkg::CH_OPEN) tok_nxt = tse_pkg::T_OPEN;
              else if (c_r == tse_pkg::CH_CLOSE) tok_nxt = tse_pkg::T_CLOSE;
              else if (c_r == tse_pkg::CH_DASH) tok_nxt = tse_pkg::T_DASH;
              else if (c_r == tse_pkg::CH_LBRACE) tok_nxt = tse_pkg::T_LBRACE;
              else if (c_r == tse_pkg::CH_RBRACE) tok_nxt = tse_pkg::T_RBRACE;
              else tok_nxt = tse_pkg::T_LIT;
            end
          endcase
        end
      end
      tse_pkg::S_PARSE: begin
        if (!pend_r || !ov_nxt) begin
          ret = relex_r ? tse_pkg::S_LEX : tse_pkg::S_FINISH;
          st_nxt = ret;
          unique case (pp_r)
            tse_pkg::P_START: begin
              if (tok_r == tse_pkg::T_EOF) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_DONE;
                pe_nxt = tse_pkg::ERR_NONE;
              end else if (tok_r == tse_pkg::T_OPEN) begin
                len_nxt = '0; pp_nxt = tse_pkg::P_IN_GEN;
              end else begin
                pushed = 1'b1; pb_nxt = val_r; pk_nxt = tse_pkg::KIND_CHAR;
                pe_nxt = tse_pkg::ERR_NONE;
              end
            end
            tse_pkg::P_IN_GEN: begin
              if (tok_r == tse_pkg::T_CLOSE) pp_nxt = tse_pkg::P_SAW_GEN;
              else if (tok_r == tse_pkg::T_EOF) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_LIT;
              end else begin
                first_nxt = val_r; pp_nxt = tse_pkg::P_SAW_FIRST;
              end
            end
            tse_pkg::P_SAW_FIRST: begin
              if (tok_r == tse_pkg::T_DASH) pp_nxt = tse_pkg::P_SAW_THROUGH;
              else if (len_r >= DEPTH_L) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_FULL;
              end else begin
                we = 1'b1; len_nxt = len_r + 1'b1; pp_nxt = tse_pkg::P_IN_GEN;
                st_nxt = tse_pkg::S_PARSE;
              end
            end
            tse_pkg::P_SAW_THROUGH: begin
              if (tok_r == tse_pkg::T_EOF || tok_r == tse_pkg::T_CLOSE) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_END;
              end else if (val_r < first_r) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_BACK;
              end else if (32'(span_w) > 32'(DEPTH_L - len_r)) begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_FULL;
              end else begin
                span_nxt = span_w; st_nxt = tse_pkg::S_FILL;
              end
            end
            tse_pkg::P_SAW_GEN: begin
              if (tok_r == tse_pkg::T_LBRACE) begin
                rep_nxt = '0; pp_nxt = tse_pkg::P_IN_COUNT;
              end else begin
                rep_nxt = 6'd1; pp_nxt = tse_pkg::P_SAW_COUNT; st_nxt = tse_pkg::S_PARSE;
              end
            end
            tse_pkg::P_IN_COUNT: begin
              if (tok_r == tse_pkg::T_RBRACE) pp_nxt = tse_pkg::P_SAW_COUNT;
              else if (tok_r == tse_pkg::T_LIT && val_r >= tse_pkg::CH_0 &&
                       val_r <= tse_pkg::CH_9) begin
                r10 = {1'b0, rep_r, 3'b000} + {3'b000, rep_r, 1'b0} +
                      10'(val_r - tse_pkg::CH_0);
                rep_nxt = (r10 > {4'b0000, CMAX}) ? CMAX : r10[5:0];
              end else begin
                pushed = 1'b1; pb_nxt = 8'd0; pk_nxt = tse_pkg::KIND_ERROR;
                pe_nxt = tse_pkg::ERR_DIGIT;
              end
            end
            tse_pkg::P_SAW_COUNT: begin
              st_nxt = tse_pkg::S_PARSE;
              if (len_r != '0 && rep_r != '0) st_nxt = tse_pkg::S_PICK_ADV;
              else pp_nxt = tse_pkg::P_START;
            end
            default: begin
              pp_nxt = tse_pkg::P_START; st_nxt = tse_pkg::S_PARSE;
            end
          endcase
          if (pushed) begin
            pend_nxt = 1'b1;
            if (pk_nxt == tse_pkg::KIND_ERROR) begin
              halted_nxt = 1'b1; disc_nxt = 1'b1; pp_nxt = tse_pkg::P_START;
              lp_nxt = tse_pkg::L_START; st_nxt = tse_pkg::S_FINISH;
            end
          end
        end
      end
      tse_pkg::S_FILL: begin
        we = 1'b1; wdata = first_r; len_nxt = len_r + 1'b1;
        first_nxt = first_r + 8'd1; span_nxt = span_r - 9'd1;
        if (span_r == 9'd1) begin
          pp_nxt = tse_pkg::P_IN_GEN;
          st_nxt = relex_r ? tse_pkg::S_LEX : tse_pkg::S_FINISH;
        end
      end
      tse_pkg::S_PICK_ADV: begin
        lfsr_nxt = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? tse_pkg::LFSR_MASK : 32'd0);
        st_nxt = tse_pkg::S_PICK_MOD;
      end
      tse_pkg::S_PICK_MOD: begin
        mstart = 1'b1; st_nxt = tse_pkg::S_PICK_RD;
      end
      tse_pkg::S_PICK_RD: if (mdone) st_nxt = tse_pkg::S_PICK_WAIT;
      tse_pkg::S_PICK_WAIT: begin
        if (!pend_r || !ov_nxt) begin
          pushed = 1'b1;
          pend_nxt = 1'b1; pb_nxt = rdata; pk_nxt = tse_pkg::KIND_CHAR;
          pe_nxt = tse_pkg::ERR_NONE; rep_nxt = rep_r - 6'd1;
          if (rep_r == 6'd1) begin
            pp_nxt = tse_pkg::P_START; st_nxt = tse_pkg::S_PARSE;
          end else st_nxt = tse_pkg::S_PICK_ADV;
        end
      end
      tse_pkg::S_FINISH: begin
        if (c_r == 8'd0) begin
          pp_nxt = tse_pkg::P_START; lp_nxt = tse_pkg::L_START; disc_nxt = 1'b0;
        end
        st_nxt = tse_pkg::S_EMIT;
      end
      tse_pkg::S_EMIT: begin
        if (!pend_r || !ov_nxt) st_nxt = tse_pkg::S_IDLE;
      end
      default: st_nxt = tse_pkg::S_IDLE;
    endcase
    // release the held result when the next one arrives; the final one carries last
    if (pend_r && !ov_nxt && (pushed || st_r == tse_pkg::S_EMIT)) begin
      ov_nxt = 1'b1; ob_nxt = pb_r; ok_nxt = pk_r; oe_nxt = pe_r;
      ol_nxt = (st_r == tse_pkg::S_EMIT);
      if (!pushed) pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tse_pkg::S_IDLE; pp_r <= tse_pkg::P_START; lp_r <= tse_pkg::L_START;
      len_r <= '0; lfsr_r <= 32'd1; disc_r <= 1'b0; halted_r <= 1'b0;
      ov_r <= 1'b0; pend_r <= 1'b0; relex_r <= 1'b0; rep_r <= '0;
      oct_r <= '0; ocnt_r <= '0; first_r <= '0;
    end else begin
      st_r <= st_nxt; pp_r <= pp_nxt; lp_r <= lp_nxt; len_r <= len_nxt;
      lfsr_r <= lfsr_nxt; disc_r <= disc_nxt; halted_r <= halted_nxt;
      ov_r <= ov_nxt; pend_r <= pend_nxt; relex_r <= relex_nxt; rep_r <= rep_nxt;
      oct_r <= oct_nxt; ocnt_r <= ocnt_nxt; first_r <= first_nxt;
    end
    c_r <= c_nxt; val_r <= val_nxt; tok_r <= tok_nxt; span_r <= span_nxt;
    ob_r <= ob_nxt; ok_r <= ok_nxt; oe_r <= oe_nxt; ol_r <= ol_nxt;
    pb_r <= pb_nxt; pk_r <= pk_nxt; pe_r <= pe_nxt;
  end
endmodule

### sv/tse_checker.sv
// Port-level checker for the salt template expander, bound to the top level.
// Depends on template_salt_expander_core_assert.svh and tse_pkg.
`timescale 1ns / 1ps
`include "template_salt_expander_core_assert.svh"
module tse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_salt_byte,
  input logic [1:0] out_result_kind,
  input logic [2:0] out_error_code
);
  logic held;
  logic not_err;
  logic not_char;
  assign held     = out_valid && out_stall;
  assign not_err  = out_valid && (out_result_kind != tse_pkg::KIND_ERROR);
  assign not_char = out_valid && (out_result_kind != tse_pkg::KIND_CHAR);
  `TSE_ASSERT_NXT(a_out_hold, clk, rst_n, held, out_valid && $stable(out_salt_byte))
  `TSE_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid, out_result_kind != 2'd3)
  `TSE_ASSERT_IMP(a_err_code, clk, rst_n, not_err, out_error_code == tse_pkg::ERR_NONE)
  `TSE_ASSERT_IMP(a_char_zero, clk, rst_n, not_char, out_salt_byte == 8'd0)
endmodule
bind template_salt_expander_core tse_checker u_tse_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_salt_byte(out_salt_byte),
  .out_result_kind(out_result_kind), .out_error_code(out_error_code));
